[rtl/matrix3_det_inverse_core_defines.svh]
// ----------------------------------------------------------------------------
// matrix3_det_inverse_core_defines.svh
// Assertion macros shared by the matrix inverse RTL.
// ----------------------------------------------------------------------------
`ifndef MATRIX3_DET_INVERSE_CORE_DEFINES_SVH
`define MATRIX3_DET_INVERSE_CORE_DEFINES_SVH

// same-cycle implication, reset masked
`define MDI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define MDI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mdi_pkg.sv]
// ----------------------------------------------------------------------------
// mdi_pkg
// Widths, stage counts and types for the 3x3 determinant / inverse core.
// ----------------------------------------------------------------------------
package mdi_pkg;

    localparam int ENT_W    = 16;   // Q3.12 input entry
    localparam int PROD_W   = 32;   // entry x entry
    localparam int COF_W    = 33;   // signed cofactor
    localparam int CMAG_W   = 32;   // cofactor magnitude
    localparam int DET_W    = 49;   // signed determinant
    localparam int INV_W    = 32;   // Q15.16 result
    localparam int LANES    = 9;
    localparam int QBITS    = 32;   // quotient bits below the overflow check
    localparam int DIV_STG  = QBITS + 1;
    localparam int PRE_STG  = 5;    // products, cofactors, det products, det sum, magnitude
    localparam int NSTAGE   = PRE_STG + DIV_STG + 1;
    localparam int IN_W     = 144;
    localparam int OUT_W    = 344;
    localparam int USER_W   = 2;

    localparam logic [INV_W-1:0] INV_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [INV_W-1:0] INV_NEG_MAG = 32'h8000_0000;

    typedef struct packed {
        logic signed [DET_W-1:0] det;
        logic                    zero;
        logic                    dneg;
        logic [LANES-1:0]        cneg;
    } side_t;

endpackage

[rtl/mdi_div_pipe.sv]
// ----------------------------------------------------------------------------
// mdi_div_pipe
// Pipelined restoring divider: (cof_mag << 28) / den, one quotient bit per
// stage, with an up-front check for quotients of 2^32 or more.
// ----------------------------------------------------------------------------
module mdi_div_pipe
(
    input  logic                                clk,
    input  logic [mdi_pkg::DIV_STG-1:0]         en,
    input  logic [mdi_pkg::CMAG_W-1:0]          cof_mag,
    input  logic [mdi_pkg::DET_W-1:0]           den,
    output logic [mdi_pkg::QBITS-1:0]           quot,
    output logic                                over
);
    import mdi_pkg::*;

    logic [DET_W-1:0] r_reg   [DIV_STG];
    logic [DET_W-1:0] den_reg [DIV_STG];
    logic [QBITS-1:0] q_reg   [DIV_STG];
    logic [3:0]       nb_reg  [DIV_STG];
    logic             hi_reg  [DIV_STG];

    // stage 0: top bits of the numerator, overflow check
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            r_reg[0]   <= DET_W'(cof_mag[CMAG_W-1:4]);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            nb_reg[0]  <= cof_mag[3:0];
            hi_reg[0]  <= (DET_W'(cof_mag[CMAG_W-1:4]) >= den);
        end
    end

    for (genvar j = 1; j < DIV_STG; j++)
    begin : g_step
        logic             nb;
        logic [DET_W:0]   r_sh;
        logic             ge;

        if (j <= 4)
        begin : g_nb
            assign nb = nb_reg[j-1][4-j];
        end
        else
        begin : g_zero
            assign nb = 1'b0;
        end

        assign r_sh = {r_reg[j-1], nb};
        assign ge   = (r_sh >= {1'b0, den_reg[j-1]});

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                r_reg[j]   <= ge ? DET_W'(r_sh - {1'b0, den_reg[j-1]}) : r_sh[DET_W-1:0];
                den_reg[j] <= den_reg[j-1];
                q_reg[j]   <= {q_reg[j-1][QBITS-2:0], ge};
                nb_reg[j]  <= nb_reg[j-1];
                hi_reg[j]  <= hi_reg[j-1];
            end
        end
    end

    assign quot = q_reg[DIV_STG-1];
    assign over = hi_reg[DIV_STG-1];

endmodule

[rtl/matrix3_det_inverse_core.sv]
// ----------------------------------------------------------------------------
// matrix3_det_inverse_core
// 3x3 determinant and inverse (adjugate / determinant) of Q3.12 matrices.
// ----------------------------------------------------------------------------
// channel | dir | fields
// s_axis  | in  | tdata: m11..m33, 16b each, lowest first (144b)
// m_axis  | out | tdata: inv11..inv33 32b each, determinant 49b (pad to 344b)
//         |     | tuser: singular, saturated
//
// One matrix per cycle sustained while m_tready holds. The divider is 32 restoring
// quotient steps plus the overflow check in each of the nine divider lanes.
// Front end: products, cofactors, det products, det sum, magnitudes.
// Reset clears only stage valid bits; payload registers are unreset.
// Each stage holds when full and the one after it cannot take its item, so bubbles
// collapse and the input keeps flowing while the output stalls until all stages fill.
// ----------------------------------------------------------------------------
`include "matrix3_det_inverse_core_defines.svh"

module matrix3_det_inverse_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mdi_pkg::IN_W-1:0]      s_tdata,   // m11,m12,m13,m21,..,m33
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mdi_pkg::OUT_W-1:0]     m_tdata,   // inv11..inv33, determinant, zero pad
    output logic [mdi_pkg::USER_W-1:0]    m_tuser    // singular, saturated
);
    import mdi_pkg::*;

    // ---------------- flow control ----------------
    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE:0]   en;

    always_comb
    begin
        en[NSTAGE] = m_tready;
        for (int k = NSTAGE - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NSTAGE-1];

    // ---------------- stage 0: 2x2 products ----------------
    logic signed [ENT_W-1:0] m [LANES];
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            m[k] = s_tdata[k*ENT_W +: ENT_W];
        end
    end

    // cofactor k = pa[k] - pb[k]; a..i = m[0]..m[8]
    logic signed [PROD_W-1:0] pa_reg  [LANES];
    logic signed [PROD_W-1:0] pb_reg  [LANES];
    logic signed [ENT_W-1:0]  abc0_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pa_reg[0] <= m[4] * m[8];  pb_reg[0] <= m[7] * m[5];
            pa_reg[1] <= m[6] * m[5];  pb_reg[1] <= m[3] * m[8];
            pa_reg[2] <= m[3] * m[7];  pb_reg[2] <= m[6] * m[4];
            pa_reg[3] <= m[7] * m[2];  pb_reg[3] <= m[1] * m[8];
            pa_reg[4] <= m[0] * m[8];  pb_reg[4] <= m[6] * m[2];
            pa_reg[5] <= m[6] * m[1];  pb_reg[5] <= m[0] * m[7];
            pa_reg[6] <= m[1] * m[5];  pb_reg[6] <= m[4] * m[2];
            pa_reg[7] <= m[3] * m[2];  pb_reg[7] <= m[0] * m[5];
            pa_reg[8] <= m[0] * m[4];  pb_reg[8] <= m[3] * m[1];
            for (int k = 0; k < 3; k++)
            begin
                abc0_reg[k] <= m[k];
            end
        end
    end

    // ---------------- stage 1: cofactors ----------------
    logic signed [COF_W-1:0] cof1_reg [LANES];
    logic signed [ENT_W-1:0] abc1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int k = 0; k < LANES; k++)
            begin
                cof1_reg[k] <= COF_W'(pa_reg[k]) - COF_W'(pb_reg[k]);
            end
            for (int k = 0; k < 3; k++)
            begin
                abc1_reg[k] <= abc0_reg[k];
            end
        end
    end

    // ---------------- stage 2: det products, cofactor magnitudes ----------------
    // lanes in output order: inverse(r,c) takes cofactor(c,r)
    logic signed [DET_W-1:0]  dp2_reg  [3];
    logic [CMAG_W-1:0]        cm2_reg  [LANES];
    logic [LANES-1:0]         cn2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                dp2_reg[k] <= DET_W'(abc1_reg[k]) * DET_W'(cof1_reg[k]);
            end
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    cn2_reg[r*3+c] <= cof1_reg[c*3+r][COF_W-1];
                    cm2_reg[r*3+c] <= cof1_reg[c*3+r][COF_W-1]
                                      ? CMAG_W'(-cof1_reg[c*3+r])
                                      : CMAG_W'(cof1_reg[c*3+r]);
                end
            end
        end
    end

    // ---------------- stage 3: determinant ----------------
    logic signed [DET_W-1:0] det3_reg;
    logic [CMAG_W-1:0]       cm3_reg [LANES];
    logic [LANES-1:0]        cn3_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            det3_reg <= dp2_reg[0] + dp2_reg[1] + dp2_reg[2];
            cm3_reg  <= cm2_reg;
            cn3_reg  <= cn2_reg;
        end
    end

    // ---------------- stage 4: divisor magnitude ----------------
    logic [DET_W-1:0]  den4_reg;
    side_t             side4_reg;
    logic [CMAG_W-1:0] cm4_reg [LANES];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            den4_reg       <= det3_reg[DET_W-1] ? DET_W'(-det3_reg) : DET_W'(det3_reg);
            side4_reg.det  <= det3_reg;
            side4_reg.zero <= (det3_reg == '0);
            side4_reg.dneg <= det3_reg[DET_W-1];
            side4_reg.cneg <= cn3_reg;
            cm4_reg        <= cm3_reg;
        end
    end

    // ---------------- stages 5..37: dividers ----------------
    logic [QBITS-1:0] quot [LANES];
    logic [LANES-1:0] over;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        mdi_div_pipe u_div
        (
            .clk     (clk),
            .en      (en[PRE_STG +: DIV_STG]),
            .cof_mag (cm4_reg[l]),
            .den     (den4_reg),
            .quot    (quot[l]),
            .over    (over[l])
        );
    end

    side_t side_reg [DIV_STG];

    always_ff @(posedge clk)
    begin
        if (en[PRE_STG])
        begin
            side_reg[0] <= side4_reg;
        end
        for (int j = 1; j < DIV_STG; j++)
        begin
            if (en[PRE_STG+j])
            begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // ---------------- stage 38: sign, saturation, output register ----------------
    side_t            side_o;
    logic [INV_W-1:0] inv_next [LANES];
    logic [LANES-1:0] clip;

    assign side_o = side_reg[DIV_STG-1];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (side_o.cneg[l] ^ side_o.dneg)
            begin
                clip[l]     = over[l] || (quot[l] > INV_NEG_MAG);
                inv_next[l] = clip[l] ? INV_NEG_MAG : INV_W'(-quot[l]);
            end
            else
            begin
                clip[l]     = over[l] || quot[l][QBITS-1];
                inv_next[l] = clip[l] ? INV_POS_MAX : quot[l];
            end
            if (side_o.zero)
            begin
                clip[l]     = 1'b0;
                inv_next[l] = '0;
            end
        end
    end

    logic [INV_W-1:0]        inv_reg [LANES];
    logic signed [DET_W-1:0] det_reg;
    logic                    sing_reg;
    logic                    sat_reg;

    always_ff @(posedge clk)
    begin
        if (en[NSTAGE-1])
        begin
            inv_reg  <= inv_next;
            det_reg  <= side_o.det;
            sing_reg <= side_o.zero;
            sat_reg  <= |clip;
        end
    end

    always_comb
    begin
        m_tdata = '0;
        for (int l = 0; l < LANES; l++)
        begin
            m_tdata[l*INV_W +: INV_W] = inv_reg[l];
        end
        m_tdata[LANES*INV_W +: DET_W] = det_reg;
    end

    assign m_tuser = {sat_reg, sing_reg};

    // ---------------- assertions ----------------
    `MDI_ASSERT_IMP(a_sing_det_zero, m_tvalid && m_tuser[0], det_reg == '0, "singular with nonzero det")
    `MDI_ASSERT_IMP(a_sing_no_sat, m_tvalid && m_tuser[0], !m_tuser[1], "singular item flagged saturated")
    `MDI_ASSERT_IMP(a_empty_out_ready, !m_tvalid, s_tready, "input stalled with empty output")
    `MDI_ASSERT_NXT(a_accept_fills, s_tvalid && s_tready, v_reg[0], "accepted item lost at entry")

endmodule
